### hdl/wav_riff_pcm16_stream_parser_unit_defines.svh
// Assertion macros for the RIFF/WAVE PCM16 parser.
// No dependencies; included by the files that carry assertions.
`ifndef WAV_RIFF_PCM16_STREAM_PARSER_UNIT_DEFINES_SVH
`define WAV_RIFF_PCM16_STREAM_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Plain property, checked every edge out of reset.
`define WRP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define WRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define WRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define WRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define WRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/wrp_pkg.sv
// Shared types and constants of the RIFF/WAVE PCM16 parser.
// No dependencies; imported by wav_riff_pcm16_stream_parser_unit.
package wrp_pkg;

  localparam int SampleBits = 16;
  localparam int OutDepth   = 4;
  localparam int OutPtrW    = $clog2(OutDepth);
  localparam int OutCntW    = $clog2(OutDepth + 1);
  localparam int CfgIndexW  = 2;

  // parse phases
  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhChdr    = 3'd1;
  localparam logic [2:0] PhPayload = 3'd2;
  localparam logic [2:0] PhPad     = 3'd3;
  localparam logic [2:0] PhSink    = 3'd4;

  // byte positions inside the file header and the chunk header
  localparam logic [3:0] HdrRiffLast  = 4'd3;
  localparam logic [3:0] HdrWaveLast  = 4'd11;
  localparam logic [3:0] ChdrTagBytes = 4'd4;
  localparam logic [3:0] ChdrLast     = 4'd7;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [31:0] FmtMinLen  = 32'd16;
  localparam logic [31:0] BitsOffset = 32'd14;
  localparam logic [15:0] PcmFormat  = 16'd1;

  localparam logic [15:0] ResetChannels = 16'd2;
  localparam logic [31:0] ResetRate     = 32'd48000;

  localparam logic [CfgIndexW-1:0] RegExpChannels = 2'd0;
  localparam logic [CfgIndexW-1:0] RegExpRate     = 2'd1;

  localparam logic KindSample = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StMalformed   = 2'd1;
  localparam logic [1:0] StUnsupported = 2'd2;

  typedef struct packed {
    logic                         kind;
    logic signed [SampleBits-1:0] sample;
    logic                         clip_start;
    logic [1:0]                   status;
    logic                         last;
  } out_item_t;

endpackage

### hdl/wav_riff_pcm16_stream_parser_unit.sv
// RIFF/WAVE PCM16 stream parser: byte-wise chunk walker and sample packer.
// Depends on wrp_pkg and wav_riff_pcm16_stream_parser_unit_defines.svh.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_ready_o    byte_value_i, end_of_file_i
//   out       source     out_valid_o/out_ready_i  item_kind_o .. last_item_o
//   cfg       sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each byte transaction is parsed in the cycle it is accepted; its results
// (a sample, a status item, or both) are registered into a four-entry output
// queue that feeds the output. One byte per cycle is sustained unless the
// queue lacks room for two results, the only case in which in_ready_o drops.
// Reset clears the parse state and loads the default channel count and rate.
// cfg_ready_o is always high; writes to unknown indexes are dropped.
`include "wav_riff_pcm16_stream_parser_unit_defines.svh"

module wav_riff_pcm16_stream_parser_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [7:0]                            byte_value_i,
  input  logic                                  end_of_file_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  item_kind_o,
  output logic signed [wrp_pkg::SampleBits-1:0] sample_value_o,
  output logic                                  clip_start_o,
  output logic [1:0]                            status_code_o,
  output logic                                  last_item_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [wrp_pkg::CfgIndexW-1:0]         cfg_index_i,
  input  logic [31:0]                           cfg_data_i
);
  import wrp_pkg::*;

  // configuration
  logic [15:0] exp_chan_q;
  logic [31:0] exp_rate_q;

  // parse state
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [15:0] fmt_format_q, fmt_format_d;
  logic [15:0] fmt_chan_q, fmt_chan_d;
  logic [31:0] fmt_rate_q, fmt_rate_d;
  logic [15:0] fmt_bits_q, fmt_bits_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        data_seen_q, data_seen_d;
  logic        bad_q, bad_d;
  logic        odd_q, odd_d;
  logic        pend_q, pend_d;
  logic [7:0]  low_q, low_d;

  // output queue
  out_item_t          queue_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0] cnt_q;

  logic        in_acc, out_pop;
  logic [31:0] off;
  logic        emit_sample;
  out_item_t   sample_item, status_item, first_item;
  logic [1:0]  status_code;
  logic [1:0]  n_push;

  assign in_ready_o  = (cnt_q <= OutCntW'(OutDepth - 2));
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_pop     = out_valid_o && out_ready_i;
  assign cfg_ready_o = 1'b1;

  // byte offset inside the current chunk payload
  assign off = len_q - left_q;

  // Next parse state for the byte on the input; committed only on acceptance.
  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    tag_d        = tag_q;
    len_d        = len_q;
    left_d       = left_q;
    fmt_format_d = fmt_format_q;
    fmt_chan_d   = fmt_chan_q;
    fmt_rate_d   = fmt_rate_q;
    fmt_bits_d   = fmt_bits_q;
    fmt_seen_d   = fmt_seen_q;
    data_seen_d  = data_seen_q;
    bad_d        = bad_q;
    odd_d        = odd_q;
    pend_d       = pend_q;
    low_d        = low_q;
    emit_sample  = 1'b0;
    sample_item  = '0;

    unique case (phase_q)
      PhHeader: begin
        tag_d = {tag_q[23:0], byte_value_i};
        if (hdr_cnt_q == HdrRiffLast && tag_d != TagRiff) bad_d = 1'b1;
        if (hdr_cnt_q == HdrWaveLast && tag_d != TagWave) bad_d = 1'b1;
        if (hdr_cnt_q == HdrWaveLast) begin
          hdr_cnt_d = '0;
          phase_d   = PhChdr;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (end_of_file_i) bad_d = 1'b1;
        end
      end
      PhChdr: begin
        // tag arrives big-endian as text, length little-endian
        if (hdr_cnt_q < ChdrTagBytes) tag_d = {tag_q[23:0], byte_value_i};
        else                          len_d = {byte_value_i, len_q[31:8]};
        if (hdr_cnt_q == ChdrLast) begin
          hdr_cnt_d = '0;
          left_d    = len_d;
          if (end_of_file_i && len_d != '0) bad_d = 1'b1;
          if (tag_q == TagFmt) begin
            if (len_d < FmtMinLen) bad_d = 1'b1;
            else                   fmt_seen_d = 1'b1;
          end else if (tag_q == TagData) begin
            data_seen_d = 1'b1;
            pend_d      = 1'b1;
            odd_d       = len_d[0];
          end
          phase_d = (len_d != '0) ? PhPayload : PhChdr;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 4'd1;
        end
      end
      PhPayload: begin
        if (tag_q == TagFmt) begin
          if (off < 32'd2) begin
            if (off[0]) fmt_format_d[15:8] = byte_value_i;
            else        fmt_format_d[7:0]  = byte_value_i;
          end else if (off < 32'd4) begin
            if (off[0]) fmt_chan_d[15:8] = byte_value_i;
            else        fmt_chan_d[7:0]  = byte_value_i;
          end else if (off < 32'd8) begin
            unique case (off[1:0])
              2'd0:    fmt_rate_d[7:0]   = byte_value_i;
              2'd1:    fmt_rate_d[15:8]  = byte_value_i;
              2'd2:    fmt_rate_d[23:16] = byte_value_i;
              default: fmt_rate_d[31:24] = byte_value_i;
            endcase
          end else if (off == BitsOffset || off == BitsOffset + 32'd1) begin
            if (off[0]) fmt_bits_d[15:8] = byte_value_i;
            else        fmt_bits_d[7:0]  = byte_value_i;
          end
        end else if (tag_q == TagData) begin
          if (!off[0]) begin
            low_d = byte_value_i;
          end else begin
            emit_sample            = 1'b1;
            sample_item.kind       = KindSample;
            sample_item.sample     = {byte_value_i, low_q};
            sample_item.clip_start = pend_q;
            sample_item.status     = StOk;
            sample_item.last       = 1'b0;
            pend_d                 = 1'b0;
          end
        end
        left_d = left_q - 32'd1;
        if (left_d == '0) phase_d = len_q[0] ? PhPad : PhChdr;
        else if (end_of_file_i) bad_d = 1'b1;
      end
      PhPad: phase_d = PhChdr;
      default: ;  // sink: drop bytes until the end of the file
    endcase

    if (bad_d) phase_d = PhSink;
  end

  // Final status from the state as this byte leaves it.
  always_comb begin
    priority if (bad_d || !fmt_seen_d || !data_seen_d) begin
      status_code = StMalformed;
    end else if (fmt_format_d != PcmFormat || fmt_chan_d != exp_chan_q ||
                 fmt_rate_d != exp_rate_q || fmt_bits_d != 16'(SampleBits)) begin
      status_code = StUnsupported;
    end else if (odd_d) begin
      status_code = StMalformed;
    end else begin
      status_code = StOk;
    end
    status_item.kind       = KindStatus;
    status_item.sample     = '0;
    status_item.clip_start = data_seen_d && pend_d;
    status_item.status     = status_code;
    status_item.last       = 1'b1;
  end

  assign first_item = emit_sample ? sample_item : status_item;
  assign n_push     = in_acc ? (2'(emit_sample) + 2'(end_of_file_i)) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_chan_q <= ResetChannels;
      exp_rate_q <= ResetRate;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegExpChannels: exp_chan_q <= cfg_data_i[15:0];
        RegExpRate:     exp_rate_q <= cfg_data_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHeader;
      hdr_cnt_q    <= '0;
      tag_q        <= '0;
      len_q        <= '0;
      left_q       <= '0;
      fmt_format_q <= '0;
      fmt_chan_q   <= '0;
      fmt_rate_q   <= '0;
      fmt_bits_q   <= '0;
      fmt_seen_q   <= 1'b0;
      data_seen_q  <= 1'b0;
      bad_q        <= 1'b0;
      odd_q        <= 1'b0;
      pend_q       <= 1'b0;
      low_q        <= '0;
    end else if (in_acc) begin
      if (end_of_file_i) begin
        // start over: the next byte opens a new file
        phase_q      <= PhHeader;
        hdr_cnt_q    <= '0;
        tag_q        <= '0;
        len_q        <= '0;
        left_q       <= '0;
        fmt_format_q <= '0;
        fmt_chan_q   <= '0;
        fmt_rate_q   <= '0;
        fmt_bits_q   <= '0;
        fmt_seen_q   <= 1'b0;
        data_seen_q  <= 1'b0;
        bad_q        <= 1'b0;
        odd_q        <= 1'b0;
        pend_q       <= 1'b0;
        low_q        <= '0;
      end else begin
        phase_q      <= phase_d;
        hdr_cnt_q    <= hdr_cnt_d;
        tag_q        <= tag_d;
        len_q        <= len_d;
        left_q       <= left_d;
        fmt_format_q <= fmt_format_d;
        fmt_chan_q   <= fmt_chan_d;
        fmt_rate_q   <= fmt_rate_d;
        fmt_bits_q   <= fmt_bits_d;
        fmt_seen_q   <= fmt_seen_d;
        data_seen_q  <= data_seen_d;
        bad_q        <= bad_d;
        odd_q        <= odd_d;
        pend_q       <= pend_d;
        low_q        <= low_d;
      end
    end
  end

  // Output queue: push up to two results, pop one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutPtrW'(n_push);
      if (out_pop) rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      cnt_q <= cnt_q + OutCntW'(n_push) - OutCntW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) queue_q[wr_ptr_q] <= first_item;
    if (n_push == 2'd2) queue_q[wr_ptr_q + OutPtrW'(1)] <= status_item;
  end

  assign item_kind_o    = queue_q[rd_ptr_q].kind;
  assign sample_value_o = queue_q[rd_ptr_q].sample;
  assign clip_start_o   = queue_q[rd_ptr_q].clip_start;
  assign status_code_o  = queue_q[rd_ptr_q].status;
  assign last_item_o    = queue_q[rd_ptr_q].last;

  `WRP_ASSERT(a_queue_bound, clk_i, rst_ni, cnt_q <= OutCntW'(OutDepth), "output queue overflow")
  `WRP_ASSERT_NXT(a_eof_restart, clk_i, rst_ni, in_acc && end_of_file_i, phase_q == PhHeader && hdr_cnt_q == '0 && !bad_q, "parse state not cleared after end of file")
  `WRP_ASSERT_IMP(a_sink_has_error, clk_i, rst_ni, phase_q == PhSink, bad_q, "sink phase without a latched error")
  `WRP_ASSERT_IMP(a_sample_clean, clk_i, rst_ni, out_valid_o && item_kind_o == KindSample, status_code_o == StOk && !last_item_o, "sample item carries status bits")
  `WRP_ASSERT_IMP(a_last_is_status, clk_i, rst_ni, out_valid_o && last_item_o, item_kind_o == KindStatus && sample_value_o == '0, "last item is not a status item")

endmodule
